FILE: rtl/mscpg_pkg.sv
// ----------------------------------------------------------------------------
// mscpg_pkg
// Shared types, codes and arithmetic helpers of the cone particle generator.
// ----------------------------------------------------------------------------
package mscpg_pkg;

	localparam int ENTRY_W = 6;
	localparam int CNT_W   = 7;

	localparam logic [2:0] CFG_ISO_RADIUS   = 3'd0;
	localparam logic [2:0] CFG_POLAR_START  = 3'd1;
	localparam logic [2:0] CFG_ROT_START    = 3'd2;
	localparam logic [2:0] CFG_ROT_STOP     = 3'd3;
	localparam logic [2:0] CFG_SHIFT_X      = 3'd4;
	localparam logic [2:0] CFG_SHIFT_Y      = 3'd5;
	localparam logic [2:0] CFG_SHIFT_Z      = 3'd6;
	localparam logic [2:0] CFG_SOURCE_COUNT = 3'd7;

	localparam logic [10:0] KEV_HIGH = 11'd1330;
	localparam logic [10:0] KEV_LOW  = 11'd1170;

	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_CAPTURE,
		CMD_SQ_INIT,
		CMD_SQ_STEP,
		CMD_AZ_INIT,
		CMD_CR_STEP,
		CMD_WYZ,
		CMD_RD,
		CMD_LON_INIT,
		CMD_ROTY,
		CMD_ROTZP,
		CMD_ROTZD,
		CMD_EMIT
	} step_t;

	typedef struct packed {
		step_t              step;
		logic [3:0]         iter;
		logic [ENTRY_W-1:0] k;
		logic               last;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} stat_t;

	function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
		logic signed [33:0] r;
		unique case (i)
			4'd0:  r = 34'sd536870912;
			4'd1:  r = 34'sd316933406;
			4'd2:  r = 34'sd167458907;
			4'd3:  r = 34'sd85004756;
			4'd4:  r = 34'sd42667330;
			4'd5:  r = 34'sd21354465;
			4'd6:  r = 34'sd10679838;
			4'd7:  r = 34'sd5340245;
			4'd8:  r = 34'sd2670163;
			4'd9:  r = 34'sd1335086;
			4'd10: r = 34'sd667544;
			4'd11: r = 34'sd333772;
			4'd12: r = 34'sd166886;
			4'd13: r = 34'sd83443;
			4'd14: r = 34'sd41722;
			4'd15: r = 34'sd20861;
		endcase
		return r;
	endfunction

	function automatic logic signed [16:0] cordic_out(input logic signed [33:0] v,
		input logic flip);
		logic signed [33:0] r;
		logic signed [16:0] s;
		r = (v + 34'sd16384) >>> 15;
		if (r > 34'sd32768) begin
			s = 17'sd32768;
		end else if (r < -34'sd32768) begin
			s = -17'sd32768;
		end else begin
			s = r[16:0];
		end
		return flip ? -s : s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [31:0] r;
		if (v > 38'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -38'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > 22'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -22'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/mscpg_ctrl.sv
// ----------------------------------------------------------------------------
// mscpg_ctrl
// Sequencer: steps the datapath through sampling and the per-source loop.
// ----------------------------------------------------------------------------
module mscpg_ctrl #(
	parameter int MAX_SOURCES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                op,
	input  mscpg_pkg::stat_t    stat,
	output mscpg_pkg::cmd_t     cmd,
	output logic                busy
);

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_SQ_INIT  = 13'b0000000000010,
		ST_SQRT     = 13'b0000000000100,
		ST_AZ_INIT  = 13'b0000000001000,
		ST_AZ       = 13'b0000000010000,
		ST_WYZ      = 13'b0000000100000,
		ST_RD       = 13'b0000001000000,
		ST_LON_INIT = 13'b0000010000000,
		ST_LON      = 13'b0000100000000,
		ST_ROTY     = 13'b0001000000000,
		ST_ROTZP    = 13'b0010000000000,
		ST_ROTZD    = 13'b0100000000000,
		ST_EMIT     = 13'b1000000000000
	} state_t;

	localparam logic [mscpg_pkg::CNT_W-1:0] MAX_CNT = mscpg_pkg::CNT_W'(MAX_SOURCES);

	state_t state_q, state_d;
	logic [3:0] it_q, it_d;
	logic [mscpg_pkg::ENTRY_W-1:0] k_q, k_d;
	logic [mscpg_pkg::CNT_W-1:0] cnt;
	logic is_last;

	assign cnt     = (stat.count > MAX_CNT) ? MAX_CNT : stat.count;
	assign is_last = ({1'b0, k_q} == cnt - 1'b1);
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		it_d     = it_q;
		k_d      = k_q;
		cmd.step = mscpg_pkg::CMD_NONE;
		cmd.iter = it_q;
		cmd.k    = k_q;
		cmd.last = is_last;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (!op) begin
						cmd.step = mscpg_pkg::CMD_LOAD;
					end else if (cnt != '0) begin
						cmd.step = mscpg_pkg::CMD_CAPTURE;
						state_d  = ST_SQ_INIT;
					end
				end
			end
			ST_SQ_INIT: begin
				cmd.step = mscpg_pkg::CMD_SQ_INIT;
				it_d     = '0;
				state_d  = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.step = mscpg_pkg::CMD_SQ_STEP;
				it_d     = it_q + 4'd1;
				if (it_q == 4'd15) begin
					state_d = ST_AZ_INIT;
				end
			end
			ST_AZ_INIT: begin
				cmd.step = mscpg_pkg::CMD_AZ_INIT;
				it_d     = '0;
				state_d  = ST_AZ;
			end
			ST_AZ: begin
				cmd.step = mscpg_pkg::CMD_CR_STEP;
				it_d     = it_q + 4'd1;
				if (it_q == 4'd15) begin
					state_d = ST_WYZ;
				end
			end
			ST_WYZ: begin
				cmd.step = mscpg_pkg::CMD_WYZ;
				k_d      = '0;
				state_d  = ST_RD;
			end
			ST_RD: begin
				cmd.step = mscpg_pkg::CMD_RD;
				state_d  = ST_LON_INIT;
			end
			ST_LON_INIT: begin
				cmd.step = mscpg_pkg::CMD_LON_INIT;
				it_d     = '0;
				state_d  = ST_LON;
			end
			ST_LON: begin
				cmd.step = mscpg_pkg::CMD_CR_STEP;
				it_d     = it_q + 4'd1;
				if (it_q == 4'd15) begin
					state_d = ST_ROTY;
				end
			end
			ST_ROTY: begin
				cmd.step = mscpg_pkg::CMD_ROTY;
				state_d  = ST_ROTZP;
			end
			ST_ROTZP: begin
				cmd.step = mscpg_pkg::CMD_ROTZP;
				state_d  = ST_ROTZD;
			end
			ST_ROTZD: begin
				cmd.step = mscpg_pkg::CMD_ROTZD;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.step = mscpg_pkg::CMD_EMIT;
				if (is_last) begin
					state_d = ST_IDLE;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			it_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			it_q    <= it_d;
			k_q     <= k_d;
		end
	end

endmodule

FILE: rtl/mscpg_dpath.sv
// ----------------------------------------------------------------------------
// mscpg_dpath
// Datapath: settings, source table, square root, shared cordic and rotations.
// ----------------------------------------------------------------------------
module mscpg_dpath #(
	parameter int MAX_SOURCES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [5:0]          entry_index,
	input  logic signed [15:0]  lat_sine,
	input  logic signed [15:0]  lat_cosine,
	input  logic [15:0]         longitude,
	input  logic [15:0]         rand_polar,
	input  logic [15:0]         rand_azimuth,
	input  logic [15:0]         rand_energy,
	input  logic [15:0]         rand_rotation,
	input  mscpg_pkg::cmd_t     cmd,
	output mscpg_pkg::stat_t    stat,
	output logic                strobe,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  pos_z,
	output logic signed [15:0]  dir_x,
	output logic signed [15:0]  dir_y,
	output logic signed [15:0]  dir_z,
	output logic [10:0]         energy_kev,
	output logic [5:0]          source_number,
	output logic                last
);

	localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

	logic [30:0]        iso_q;
	logic signed [15:0] ps_q;
	logic [15:0]        rs_q, re_q;
	logic signed [31:0] sx_q, sy_q, sz_q;
	logic [6:0]         scnt_q;

	logic [47:0] mem [MAX_SOURCES];
	logic [47:0] rd_q;

	logic signed [16:0] c_q;
	logic [15:0]        rot_q, az_q;
	logic [10:0]        kev_q;
	logic [31:0]        n_q, res_q, bit_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               flip_q;
	logic signed [16:0] wy_q, wz_q;
	logic signed [33:0] pz_q, px_q;
	logic signed [18:0] dz_q, dx_q;
	logic signed [36:0] px2_q, py_q;
	logic signed [21:0] dx2_q, dy_q;

	assign stat.count = scnt_q;

	// sampling of the cone cosine and rotation angle
	logic signed [17:0] pdiff;
	logic signed [34:0] cprod;
	logic signed [17:0] c_n;
	logic signed [16:0] rdiff;
	logic signed [33:0] rprod;

	assign pdiff = 18'sd32768 - ps_q;
	assign cprod = pdiff * $signed({1'b0, rand_polar});
	assign c_n   = ps_q + $signed({1'b0, cprod[32:16]});
	assign rdiff = $signed({1'b0, re_q}) - $signed({1'b0, rs_q});
	assign rprod = rdiff * $signed({1'b0, rand_rotation});

	// square root
	logic signed [33:0] csq;
	logic [31:0]        sq_t;

	assign csq  = c_q * c_q;
	assign sq_t = res_q + bit_q;

	// cordic
	logic [15:0]        ang;
	logic               ang_flip;
	logic [31:0]        ang32;
	logic signed [33:0] xs, ys, at;
	logic signed [16:0] cs_w, sn_w;

	assign ang      = (cmd.step == mscpg_pkg::CMD_AZ_INIT) ? az_q : rd_q[15:0] + rot_q;
	assign ang_flip = ang[15] ^ ang[14];
	assign ang32    = {ang[15] ^ ang_flip, ang[14:0], 16'h0000};
	assign xs       = cx_q >>> cmd.iter;
	assign ys       = cy_q >>> cmd.iter;
	assign at       = mscpg_pkg::atan_turn(cmd.iter);
	assign cs_w     = mscpg_pkg::cordic_out(cx_q, flip_q);
	assign sn_w     = mscpg_pkg::cordic_out(cy_q, flip_q);

	// cone direction
	logic signed [17:0] stv;
	logic signed [34:0] wyp, wzp, wys, wzs;

	assign stv = $signed({1'b0, res_q[16:0]});
	assign wyp = stv * sn_w;
	assign wzp = stv * cs_w;
	assign wys = (wyp + 35'sd16384) >>> 15;
	assign wzs = (wzp + 35'sd16384) >>> 15;

	// rotation about y
	logic signed [15:0] sn_t, cs_t;
	logic signed [31:0] iso_s, xv;
	logic signed [47:0] pzm, pxm, pzs, pxs;
	logic signed [33:0] dzm, dxm, dzs, dxs;

	assign sn_t  = $signed(rd_q[47:32]);
	assign cs_t  = $signed(rd_q[31:16]);
	assign iso_s = $signed({1'b0, iso_q});
	assign xv    = -iso_s;
	assign pzm   = sn_t * iso_s;
	assign pxm   = cs_t * xv;
	assign pzs   = (pzm + 48'sd16384) >>> 15;
	assign pxs   = (pxm + 48'sd16384) >>> 15;
	assign dzm   = cs_t * wz_q - sn_t * c_q;
	assign dxm   = sn_t * wz_q + cs_t * c_q;
	assign dzs   = (dzm + 34'sd16384) >>> 15;
	assign dxs   = (dxm + 34'sd16384) >>> 15;

	// rotation about z
	logic signed [51:0] pxm2, pym2, pxs2, pys2;
	logic signed [37:0] dxm2, dym2, dxs2, dys2;

	assign pxm2 = cs_w * px_q;
	assign pym2 = sn_w * px_q;
	assign pxs2 = (pxm2 + 52'sd16384) >>> 15;
	assign pys2 = (pym2 + 52'sd16384) >>> 15;
	assign dxm2 = cs_w * dx_q - sn_w * wy_q;
	assign dym2 = sn_w * dx_q + cs_w * wy_q;
	assign dxs2 = (dxm2 + 38'sd16384) >>> 15;
	assign dys2 = (dym2 + 38'sd16384) >>> 15;

	// shift
	logic signed [37:0] ex, ey, ez;

	assign ex = px2_q + sx_q;
	assign ey = py_q + sy_q;
	assign ez = pz_q + sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q  <= '0;
			ps_q   <= 16'sd32767;
			rs_q   <= '0;
			re_q   <= '0;
			sx_q   <= '0;
			sy_q   <= '0;
			sz_q   <= '0;
			scnt_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mscpg_pkg::CFG_ISO_RADIUS:   iso_q  <= cfg_data[30:0];
				mscpg_pkg::CFG_POLAR_START:  ps_q   <= $signed(cfg_data[15:0]);
				mscpg_pkg::CFG_ROT_START:    rs_q   <= cfg_data[15:0];
				mscpg_pkg::CFG_ROT_STOP:     re_q   <= cfg_data[15:0];
				mscpg_pkg::CFG_SHIFT_X:      sx_q   <= $signed(cfg_data);
				mscpg_pkg::CFG_SHIFT_Y:      sy_q   <= $signed(cfg_data);
				mscpg_pkg::CFG_SHIFT_Z:      sz_q   <= $signed(cfg_data);
				mscpg_pkg::CFG_SOURCE_COUNT: scnt_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step == mscpg_pkg::CMD_LOAD && {26'd0, entry_index} < MAX_SOURCES) begin
			mem[entry_index[IW-1:0]] <= {lat_sine, lat_cosine, longitude};
		end
		if (cmd.step == mscpg_pkg::CMD_RD) begin
			rd_q <= mem[cmd.k[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.step)
			mscpg_pkg::CMD_CAPTURE: begin
				c_q   <= c_n[16:0];
				rot_q <= rs_q + rprod[31:16];
				az_q  <= rand_azimuth;
				kev_q <= rand_energy[15] ? mscpg_pkg::KEV_LOW : mscpg_pkg::KEV_HIGH;
			end
			mscpg_pkg::CMD_SQ_INIT: begin
				n_q   <= 32'h4000_0000 - csq[31:0];
				res_q <= '0;
				bit_q <= 32'h4000_0000;
			end
			mscpg_pkg::CMD_SQ_STEP: begin
				if (n_q >= sq_t) begin
					n_q   <= n_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			mscpg_pkg::CMD_AZ_INIT, mscpg_pkg::CMD_LON_INIT: begin
				cx_q   <= mscpg_pkg::CORDIC_GAIN;
				cy_q   <= '0;
				cz_q   <= {{2{ang32[31]}}, ang32};
				flip_q <= ang_flip;
			end
			mscpg_pkg::CMD_CR_STEP: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			mscpg_pkg::CMD_WYZ: begin
				wy_q <= wys[16:0];
				wz_q <= wzs[16:0];
			end
			mscpg_pkg::CMD_ROTY: begin
				pz_q <= pzs[33:0];
				px_q <= pxs[33:0];
				dz_q <= dzs[18:0];
				dx_q <= dxs[18:0];
			end
			mscpg_pkg::CMD_ROTZP: begin
				px2_q <= pxs2[36:0];
				py_q  <= pys2[36:0];
			end
			mscpg_pkg::CMD_ROTZD: begin
				dx2_q <= dxs2[21:0];
				dy_q  <= dys2[21:0];
			end
			mscpg_pkg::CMD_EMIT: begin
				pos_x         <= mscpg_pkg::sat32(ex);
				pos_y         <= mscpg_pkg::sat32(ey);
				pos_z         <= mscpg_pkg::sat32(ez);
				dir_x         <= mscpg_pkg::sat16(dx2_q);
				dir_y         <= mscpg_pkg::sat16(dy_q);
				dir_z         <= mscpg_pkg::sat16({{3{dz_q[18]}}, dz_q});
				energy_kev    <= kev_q;
				source_number <= cmd.k;
				last          <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= (cmd.step == mscpg_pkg::CMD_EMIT);
		end
	end

endmodule

FILE: rtl/multi_source_cone_particle_generator_core.sv
// ----------------------------------------------------------------------------
// multi_source_cone_particle_generator_core
// Cone direction sampler that emits one Co-60 photon start per source in the source count.
//
//  channel   handshake        fields
//  input     start / busy     op, entry_index, lat_*, longitude, rand_*
//  result    strobe           pos_*, dir_*, energy_kev, source_number, last
//  config    cfg_we           cfg_index, cfg_data
//
// a load beat leaves busy low
// a generate beat runs the set-up (square root and azimuth cordic, 16 steps
// each) and then the per-source loop on the shared cordic
// a generate beat with a source count of zero gives no result and busy stays low
// results come one per strobe cycle and cannot be held off
// reset zeroes settings but polar start (32767); table is empty until loaded
// ----------------------------------------------------------------------------
module multi_source_cone_particle_generator_core #(
	parameter int MAX_SOURCES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic                op,
	input  logic [5:0]          entry_index,
	input  logic signed [15:0]  lat_sine,
	input  logic signed [15:0]  lat_cosine,
	input  logic [15:0]         longitude,
	input  logic [15:0]         rand_polar,
	input  logic [15:0]         rand_azimuth,
	input  logic [15:0]         rand_energy,
	input  logic [15:0]         rand_rotation,
	output logic                strobe,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  pos_z,
	output logic signed [15:0]  dir_x,
	output logic signed [15:0]  dir_y,
	output logic signed [15:0]  dir_z,
	output logic [10:0]         energy_kev,
	output logic [5:0]          source_number,
	output logic                last
);

	mscpg_pkg::cmd_t  cmd;
	mscpg_pkg::stat_t stat;

	mscpg_ctrl #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	mscpg_dpath #(
		.MAX_SOURCES(MAX_SOURCES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.entry_index   (entry_index),
		.lat_sine      (lat_sine),
		.lat_cosine    (lat_cosine),
		.longitude     (longitude),
		.rand_polar    (rand_polar),
		.rand_azimuth  (rand_azimuth),
		.rand_energy   (rand_energy),
		.rand_rotation (rand_rotation),
		.cmd           (cmd),
		.stat          (stat),
		.strobe        (strobe),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.dir_x         (dir_x),
		.dir_y         (dir_y),
		.dir_z         (dir_z),
		.energy_kev    (energy_kev),
		.source_number (source_number),
		.last          (last)
	);

endmodule
